FILE: sv/bmp_stream_to_rgb565_decoder_core_defines.svh
// Assertion macros shared by the decoder RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BMP_STREAM_TO_RGB565_DECODER_CORE_DEFINES_SVH
`define BMP_STREAM_TO_RGB565_DECODER_CORE_DEFINES_SVH

// hold cond on every clock edge out of reset
`define BMPDEC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bmpdec assertion failed");

// cons must hold in the same cycle as ante
`define BMPDEC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmpdec assertion failed");

// cons must hold in the cycle after ante
`define BMPDEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmpdec assertion failed");

`endif

FILE: sv/bmpdec_pkg.sv
// Types and codes of the BMP to RGB565 decoder.
// No dependencies; used by the interfaces and the core.
package bmpdec_pkg;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ST_NOT_BMP       = 3'd0;
    localparam logic [2:0] ST_TRUNC_HEADER  = 3'd1;
    localparam logic [2:0] ST_PLANES        = 3'd2;
    localparam logic [2:0] ST_DEPTH         = 3'd3;
    localparam logic [2:0] ST_SIZE_MISMATCH = 3'd4;
    localparam logic [2:0] ST_COMPRESSION   = 3'd5;
    localparam logic [2:0] ST_PIXELS_SHORT  = 3'd6;
    localparam logic [2:0] ST_DIMENSION     = 3'd7;

    localparam logic [7:0] MAGIC_B = 8'h42;
    localparam logic [7:0] MAGIC_M = 8'h4D;
    localparam logic [31:0] CORE_HDR_SIZE = 32'd12;

    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel_value;
        logic [19:0] pixel_index;
        logic        last_pixel;
        logic [2:0]  status_code;
        logic [10:0] image_width;
        logic [10:0] image_height;
        logic        is_24bpp;
        logic        top_down;
    } out_item_t;

endpackage

FILE: sv/bmpdec_in_if.sv
// Byte channel into the decoder: valid, ready and one input item.
// Depends on bmpdec_pkg.
interface bmpdec_in_if import bmpdec_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/bmpdec_out_if.sv
// Result channel out of the decoder: valid, ready and one result item.
// Depends on bmpdec_pkg.
interface bmpdec_out_if import bmpdec_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/bmp_stream_to_rgb565_decoder_core.sv
// Streaming BMP parser emitting RGB565 pixels, header and error items.
// Depends on bmpdec_pkg, bmpdec_in_if, bmpdec_out_if and the defines header.
//
//   channel  | dir | item
//   ---------+-----+-------------------------------------------
//   in       | in  | action, byte_value (one file byte or end)
//   out      | out | kind, pixel/header fields, status_code
//
// One byte is taken per cycle; its result, if any, sits in the output
// register from the next cycle. in.ready is low only while that register
// is full and out.ready is low. The header size check and the first row
// base use two small multipliers in the cycle of the depth byte. Reset
// rearms at the magic.
`include "bmp_stream_to_rgb565_decoder_core_defines.svh"

module bmp_stream_to_rgb565_decoder_core
    import bmpdec_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)(
    input  logic         clk,
    input  logic         rst_n,
    bmpdec_in_if.sink    in,
    bmpdec_out_if.source out
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int BW = WW + 5;
    localparam int PW = BW + HW;
    localparam int SW = ((PW > 32) ? PW : 32) + 2;

    typedef enum logic [2:0] {
        PH_MAGIC0, PH_MAGIC1, PH_HEADER, PH_SKIP, PH_PIXELS, PH_PAD, PH_DONE, PH_ERROR
    } phase_t;

    typedef enum logic [3:0] {
        F_SKIP, F_FSIZE, F_PSTART, F_DIB, F_W, F_H, F_PL, F_BPP, F_COMP
    } field_t;

    phase_t phase_reg, phase_next;
    logic [31:0] off_reg, off_next;
    logic [1:0] lane_reg, lane_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] fsize_reg, fsize_next;
    logic [31:0] pso_reg, pso_next;
    logic core_reg, core_next;
    logic [31:0] raw_w_reg, raw_w_next;
    logic [31:0] raw_h_reg, raw_h_next;
    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    logic flip_reg, flip_next;
    logic d24_reg, d24_next;
    logic [2:0] rpad_reg, rpad_next;
    logic [WW-1:0] col_reg, col_next;
    logic [HW-1:0] row_reg, row_next;
    logic [19:0] rbase_reg, rbase_next;
    logic [2:0] padrem_reg, padrem_next;
    logic [1:0] pbc_reg, pbc_next;
    logic [15:0] ppart_reg, ppart_next;
    logic out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic take;
    logic res_valid;
    logic res_img;
    out_item_t res;
    field_t fld;
    logic fld_end;
    logic [7:0] b;
    logic [5:0] o6;
    logic [31:0] acc_new;
    logic [15:0] bpp;
    logic bpp_ok;
    logic dim_bad;
    logic [31:0] ah;
    logic [WW-1:0] wv;
    logic [HW-1:0] ahv;
    logic [BW-1:0] bits;
    logic [BW-1:0] bpr;
    logic [PW-1:0] prod;
    logic signed [SW-1:0] expect_size;
    logic size_ok;
    logic [2:0] bytes_lo;
    logic [2:0] pad_lo;
    logic [WW-1:0] weff;
    logic hflip;
    logic [WW+HW-1:0] base0;
    logic [15:0] pix;
    logic [31:0] off_inc;

    assign in.ready  = !out_valid_reg || out.ready;
    assign take      = in.valid && in.ready;
    assign out.valid = out_valid_reg;
    assign out.data  = out_data_reg;
    assign b         = in.data.byte_value;
    assign o6        = off_reg[5:0];
    assign off_inc   = off_reg + 32'd1;

    always_comb
    begin
        fld     = F_SKIP;
        fld_end = 1'b0;
        if (o6 <= 6'd5)
        begin
            fld = F_FSIZE;  fld_end = (o6 == 6'd5);
        end
        else if (o6 <= 6'd9)
        begin
            fld = F_SKIP;
        end
        else if (o6 <= 6'd13)
        begin
            fld = F_PSTART; fld_end = (o6 == 6'd13);
        end
        else if (o6 <= 6'd17)
        begin
            fld = F_DIB;    fld_end = (o6 == 6'd17);
        end
        else if (core_reg)
        begin
            if (o6 <= 6'd19)
            begin
                fld = F_W;   fld_end = (o6 == 6'd19);
            end
            else if (o6 <= 6'd21)
            begin
                fld = F_H;   fld_end = (o6 == 6'd21);
            end
            else if (o6 <= 6'd23)
            begin
                fld = F_PL;  fld_end = (o6 == 6'd23);
            end
            else
            begin
                fld = F_BPP; fld_end = (o6 == 6'd25);
            end
        end
        else if (o6 <= 6'd21)
        begin
            fld = F_W;    fld_end = (o6 == 6'd21);
        end
        else if (o6 <= 6'd25)
        begin
            fld = F_H;    fld_end = (o6 == 6'd25);
        end
        else if (o6 <= 6'd27)
        begin
            fld = F_PL;   fld_end = (o6 == 6'd27);
        end
        else if (o6 <= 6'd29)
        begin
            fld = F_BPP;  fld_end = (o6 == 6'd29);
        end
        else
        begin
            fld = F_COMP; fld_end = (o6 == 6'd33);
        end
    end

    always_comb
    begin
        acc_new = (lane_reg == 2'd0) ? {24'd0, b} : (acc_reg | ({24'd0, b} << {lane_reg, 3'b000}));
        bpp     = acc_new[15:0];
        bpp_ok  = (bpp == 16'd16) || (bpp == 16'd24);
        ah      = raw_h_reg[31] ? (~raw_h_reg + 32'd1) : raw_h_reg;
        dim_bad = raw_w_reg[31] || (raw_w_reg < 32'd2) || (raw_w_reg > 32'(MAX_WIDTH))
                  || (ah == 32'd0) || (ah > 32'(MAX_HEIGHT));
        wv      = raw_w_reg[WW-1:0];
        ahv     = ah[HW-1:0];
        bits    = (BW'(wv) << 4) + ((bpp == 16'd24) ? (BW'(wv) << 3) : BW'(0));
        bpr     = ((bits + BW'(31)) >> 5) << 2;
        prod    = PW'(bpr) * PW'(ahv);
        expect_size = SW'($signed(pso_reg)) + $signed({2'b00, prod});
        size_ok = (SW'($signed(fsize_reg)) == expect_size);
        bytes_lo = (bpp == 16'd24) ? (wv[2:0] + {wv[1:0], 1'b0}) : {wv[1:0], 1'b0};
        pad_lo  = bpr[2:0] - bytes_lo + (wv[0] ? ((bpp == 16'd24) ? 3'd3 : 3'd2) : 3'd0);
        weff    = {wv[WW-1:1], 1'b0};
        hflip   = !raw_h_reg[31] && (raw_h_reg != 32'd0);
        base0   = hflip ? ((WW+HW)'(ahv - HW'(1)) * (WW+HW)'(weff)) : '0;
        pix     = d24_reg ? {b[7:3], ppart_reg[10:0]} : {b, ppart_reg[7:0]};
    end

    always_comb
    begin
        phase_next  = phase_reg;
        off_next    = off_reg;
        lane_next   = lane_reg;
        acc_next    = acc_reg;
        fsize_next  = fsize_reg;
        pso_next    = pso_reg;
        core_next   = core_reg;
        raw_w_next  = raw_w_reg;
        raw_h_next  = raw_h_reg;
        width_next  = width_reg;
        height_next = height_reg;
        flip_next   = flip_reg;
        d24_next    = d24_reg;
        rpad_next   = rpad_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        rbase_next  = rbase_reg;
        padrem_next = padrem_reg;
        pbc_next    = pbc_reg;
        ppart_next  = ppart_reg;
        res_valid   = 1'b0;
        res_img     = 1'b0;
        res         = '0;

        if (take)
        begin
            if (in.data.action)
            begin
                unique case (phase_reg)
                    PH_MAGIC0, PH_MAGIC1:
                    begin
                        res_valid = 1'b1; res.kind = KIND_ERROR; res.status_code = ST_NOT_BMP;
                    end
                    PH_HEADER, PH_SKIP:
                    begin
                        res_valid = 1'b1; res.kind = KIND_ERROR;
                        res.status_code = ST_TRUNC_HEADER;
                    end
                    PH_PIXELS, PH_PAD:
                    begin
                        res_valid = 1'b1; res.kind = KIND_ERROR;
                        res.status_code = ST_PIXELS_SHORT;
                    end
                    default: ;
                endcase
                phase_next  = PH_MAGIC0;
                off_next    = '0;
                lane_next   = '0;
                acc_next    = '0;
                fsize_next  = '0;
                pso_next    = '0;
                core_next   = 1'b0;
                raw_w_next  = '0;
                raw_h_next  = '0;
                width_next  = '0;
                height_next = '0;
                flip_next   = 1'b0;
                d24_next    = 1'b0;
                rpad_next   = '0;
                col_next    = '0;
                row_next    = '0;
                rbase_next  = '0;
                padrem_next = '0;
                pbc_next    = '0;
                ppart_next  = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_MAGIC0:
                    begin
                        if (b != MAGIC_B)
                        begin
                            res_valid = 1'b1; res.kind = KIND_ERROR;
                            res.status_code = ST_NOT_BMP; phase_next = PH_ERROR;
                        end
                        else
                        begin
                            phase_next = PH_MAGIC1; off_next = 32'd1;
                        end
                    end
                    PH_MAGIC1:
                    begin
                        if (b != MAGIC_M)
                        begin
                            res_valid = 1'b1; res.kind = KIND_ERROR;
                            res.status_code = ST_NOT_BMP; phase_next = PH_ERROR;
                        end
                        else
                        begin
                            phase_next = PH_HEADER; off_next = 32'd2;
                        end
                    end
                    PH_HEADER:
                    begin
                        off_next = off_inc;
                        if (fld != F_SKIP)
                        begin
                            acc_next  = acc_new;
                            lane_next = fld_end ? 2'd0 : lane_reg + 2'd1;
                        end
                        if ((fld != F_SKIP) && fld_end)
                        begin
                            unique case (fld)
                                F_FSIZE:  fsize_next = acc_new;
                                F_PSTART: pso_next   = acc_new;
                                F_DIB:    core_next  = (acc_new == CORE_HDR_SIZE);
                                F_W:      raw_w_next = core_reg ?
                                              {{16{acc_new[15]}}, acc_new[15:0]} : acc_new;
                                F_H:      raw_h_next = core_reg ?
                                              {{16{acc_new[15]}}, acc_new[15:0]} : acc_new;
                                F_PL:
                                begin
                                    if (acc_new[15:0] != 16'd1)
                                    begin
                                        res_valid = 1'b1; res.kind = KIND_ERROR;
                                        res.status_code = ST_PLANES; phase_next = PH_ERROR;
                                    end
                                end
                                F_BPP:
                                begin
                                    if (!bpp_ok || dim_bad || !size_ok)
                                    begin
                                        res_valid = 1'b1; res.kind = KIND_ERROR;
                                        phase_next = PH_ERROR;
                                        res.status_code = !bpp_ok ? ST_DEPTH :
                                            (dim_bad ? ST_DIMENSION : ST_SIZE_MISMATCH);
                                    end
                                    else
                                    begin
                                        d24_next    = (bpp == 16'd24);
                                        flip_next   = hflip;
                                        height_next = ahv;
                                        width_next  = weff;
                                        rpad_next   = pad_lo;
                                        rbase_next  = 20'(base0);
                                        if (core_reg)
                                        begin
                                            res_valid = 1'b1; res_img = 1'b1;
                                            res.kind = KIND_HEADER;
                                            phase_next = (pso_reg[31] || (pso_reg <= off_inc))
                                                ? PH_PIXELS : PH_SKIP;
                                        end
                                    end
                                end
                                default:
                                begin
                                    if ((acc_new != 32'd0) && (acc_new != 32'd3))
                                    begin
                                        res_valid = 1'b1; res.kind = KIND_ERROR;
                                        res.status_code = ST_COMPRESSION;
                                        phase_next = PH_ERROR;
                                    end
                                    else
                                    begin
                                        res_valid = 1'b1; res_img = 1'b1;
                                        res.kind = KIND_HEADER;
                                        phase_next = (pso_reg[31] || (pso_reg <= off_inc))
                                            ? PH_PIXELS : PH_SKIP;
                                    end
                                end
                            endcase
                            if (res_img)
                            begin
                                col_next    = '0;
                                row_next    = '0;
                                padrem_next = '0;
                                pbc_next    = '0;
                                ppart_next  = '0;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        off_next = off_inc;
                        if (pso_reg[31] || (pso_reg <= off_inc))
                            phase_next = PH_PIXELS;
                    end
                    PH_PIXELS:
                    begin
                        if (pbc_reg == 2'd0)
                        begin
                            pbc_next   = 2'd1;
                            ppart_next = d24_reg ? {11'd0, b[7:3]} : {8'd0, b};
                        end
                        else if (d24_reg && (pbc_reg == 2'd1))
                        begin
                            pbc_next   = 2'd2;
                            ppart_next = ppart_reg | {5'd0, b[7:2], 5'd0};
                        end
                        else
                        begin
                            pbc_next   = '0;
                            ppart_next = '0;
                            res_valid  = 1'b1;
                            res_img    = 1'b1;
                            res.kind   = KIND_PIXEL;
                            res.pixel_value = pix;
                            res.pixel_index = rbase_reg + 20'(col_reg);
                            col_next = col_reg + WW'(1);
                            if ((col_reg + WW'(1)) >= width_reg)
                            begin
                                col_next = '0;
                                row_next = row_reg + HW'(1);
                                if ((row_reg + HW'(1)) >= height_reg)
                                begin
                                    res.last_pixel = 1'b1;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    rbase_next  = flip_reg ? rbase_reg - 20'(width_reg)
                                                           : rbase_reg + 20'(width_reg);
                                    padrem_next = rpad_reg;
                                    if (rpad_reg != 3'd0)
                                        phase_next = PH_PAD;
                                end
                            end
                        end
                    end
                    PH_PAD:
                    begin
                        padrem_next = (padrem_reg != 3'd0) ? padrem_reg - 3'd1 : padrem_reg;
                        if (padrem_next == 3'd0)
                            phase_next = PH_PIXELS;
                    end
                    default: ;
                endcase
            end
        end

        if (res_img)
        begin
            res.image_width  = 11'(width_next);
            res.image_height = 11'(height_next);
            res.is_24bpp     = d24_next;
            res.top_down     = !flip_next;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (take && res_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC0;
            off_reg       <= '0;
            lane_reg      <= '0;
            acc_reg       <= '0;
            fsize_reg     <= '0;
            pso_reg       <= '0;
            core_reg      <= 1'b0;
            raw_w_reg     <= '0;
            raw_h_reg     <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            flip_reg      <= 1'b0;
            d24_reg       <= 1'b0;
            rpad_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            rbase_reg     <= '0;
            padrem_reg    <= '0;
            pbc_reg       <= '0;
            ppart_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            off_reg       <= off_next;
            lane_reg      <= lane_next;
            acc_reg       <= acc_next;
            fsize_reg     <= fsize_next;
            pso_reg       <= pso_next;
            core_reg      <= core_next;
            raw_w_reg     <= raw_w_next;
            raw_h_reg     <= raw_h_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            flip_reg      <= flip_next;
            d24_reg       <= d24_next;
            rpad_reg      <= rpad_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            rbase_reg     <= rbase_next;
            padrem_reg    <= padrem_next;
            pbc_reg       <= pbc_next;
            ppart_reg     <= ppart_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    `BMPDEC_ASSERT_IMPLY(a_pad_nonzero, phase_reg == PH_PAD, padrem_reg != 3'd0)
    `BMPDEC_ASSERT_IMPLY(a_col_in_row, (phase_reg == PH_PIXELS) || (phase_reg == PH_PAD), col_reg < width_reg)
    `BMPDEC_ASSERT_IMPLY(a_err_clean, out_valid_reg && (out_data_reg.kind == KIND_ERROR), (out_data_reg.image_width == 11'd0) && (out_data_reg.pixel_value == 16'd0))
    `BMPDEC_ASSERT_NEXT(a_rearm, take && in.data.action, (phase_reg == PH_MAGIC0) && (off_reg == 32'd0))

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for bmp_stream_to_rgb565_decoder_core: a directed table, then
// random BMP files (good, broken, truncated, noise), checked by an in-bench decoder model.
// Depends on bmpdec_pkg, bmpdec_in_if, bmpdec_out_if and the core.
module tb_top
    import bmpdec_pkg::*;
();

    localparam int     MAX_W      = 1024;
    localparam int     MAX_H      = 1024;
    localparam longint CYCLE_CAP  = 400000;
    localparam int     ITEM_COUNT = 1600;

    typedef enum logic [2:0] {
        P_MAGIC0, P_MAGIC1, P_HEADER, P_SKIP, P_PIXELS, P_PAD, P_DONE, P_ERROR
    } parse_phase_t;

    typedef enum int {
        F_SKIP, F_FSIZE, F_PSTART, F_DIB, F_W, F_H, F_PL, F_BPP, F_COMP
    } hdr_field_t;

    typedef struct {
        in_item_t  it;
        bit        typed;
        bit        want;
        out_item_t res;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bmpdec_in_if  in_ch();
    bmpdec_out_if out_ch();

    bmp_stream_to_rgb565_decoder_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    always #6 clk = ~clk;

    table_row_t  directed_rows[$];
    in_item_t    stim_items[$];
    out_item_t   pending_results[$];
    int          fail_count = 0;
    longint      cycle_count = 0;
    bit          quiet = 1'b0;
    int          pause_at = -1;

    parse_phase_t ph;
    int unsigned  boff, fshift, facc, fsize, pstart;
    bit           core_hdr;
    longint       raw_w, raw_h;
    int unsigned  wreg, hreg;
    bit           flip, d24;
    int unsigned  rpad, col, row, rbase, padrem, pbc, ppart;

    function automatic void clear_state();
        ph = P_MAGIC0;
        boff = 0; fshift = 0; facc = 0; fsize = 0; pstart = 0; core_hdr = 0;
        raw_w = 0; raw_h = 0; wreg = 0; hreg = 0; flip = 0; d24 = 0;
        rpad = 0; col = 0; row = 0; rbase = 0; padrem = 0; pbc = 0; ppart = 0;
    endfunction

    function automatic longint s32(input int unsigned v);
        return longint'($signed(v));
    endfunction

    function automatic longint s16(input int unsigned v);
        return longint'($signed(v[15:0]));
    endfunction

    function automatic void image_fields(inout out_item_t r);
        r.image_width  = wreg[10:0];
        r.image_height = hreg[10:0];
        r.is_24bpp     = d24;
        r.top_down     = !flip;
    endfunction

    function automatic bit raise(input logic [2:0] code, output out_item_t r);
        r = '0;
        r.kind = KIND_ERROR;
        r.status_code = code;
        ph = P_ERROR;
        return 1'b1;
    endfunction

    function automatic void set_row_base();
        int unsigned fr;
        fr = flip ? (hreg - 1 - row) : row;
        rbase = fr * wreg;
    endfunction

    function automatic bit header_done(output out_item_t r);
        col = 0; row = 0; padrem = 0; pbc = 0; ppart = 0;
        set_row_base();
        ph = (s32(pstart) <= longint'(boff)) ? P_PIXELS : P_SKIP;
        r = '0;
        r.kind = KIND_HEADER;
        image_fields(r);
        return 1'b1;
    endfunction

    function automatic hdr_field_t field_at(input int unsigned o, output int unsigned e);
        int unsigned k;
        if (o <= 5) begin e = 5; return F_FSIZE; end
        if (o <= 9) begin e = 9; return F_SKIP; end
        if (o <= 13) begin e = 13; return F_PSTART; end
        if (o <= 17) begin e = 17; return F_DIB; end
        if (core_hdr)
        begin
            k = (o - 18) / 2;
            if (k > 3) k = 3;
            e = 18 + 2 * k + 1;
            return hdr_field_t'(int'(F_W) + int'(k));
        end
        if (o <= 21) begin e = 21; return F_W; end
        if (o <= 25) begin e = 25; return F_H; end
        if (o <= 27) begin e = 27; return F_PL; end
        if (o <= 29) begin e = 29; return F_BPP; end
        e = 33;
        return F_COMP;
    endfunction

    function automatic int depth_check(input int unsigned bpp);
        longint ah, w, bpr, pad, want_size;
        if (bpp != 16 && bpp != 24) return int'(ST_DEPTH);
        ah = (raw_h < 0) ? -raw_h : raw_h;
        w = raw_w;
        if (w < 2 || w > MAX_W || ah == 0 || ah > MAX_H) return int'(ST_DIMENSION);
        bpr = 4 * ((longint'(bpp) * w + 31) / 32);
        pad = bpr - w * longint'(bpp) / 8;
        want_size = s32(pstart) + bpr * ah;
        if (s32(fsize) != want_size) return int'(ST_SIZE_MISMATCH);
        d24 = (bpp == 24);
        flip = (raw_h > 0);
        hreg = int'(ah);
        wreg = int'(w);
        if (w[0])
        begin
            wreg = wreg - 1;
            pad = pad + longint'(bpp) / 8;
        end
        rpad = int'(pad) & 7;
        return -1;
    endfunction

    function automatic bit header_byte(input int unsigned b, output out_item_t r);
        int unsigned o, e;
        hdr_field_t  f;
        int          code;
        o = boff;
        f = field_at(o, e);
        boff = o + 1;
        r = '0;
        if (f == F_SKIP) return 1'b0;
        if (fshift == 0) facc = b;
        else facc = facc | (b << (fshift & 31));
        fshift = fshift + 8;
        if (o != e) return 1'b0;
        fshift = 0;
        case (f)
            F_FSIZE:  fsize = facc;
            F_PSTART: pstart = facc;
            F_DIB:    core_hdr = (facc == CORE_HDR_SIZE);
            F_W:      raw_w = core_hdr ? s16(facc) : s32(facc);
            F_H:      raw_h = core_hdr ? s16(facc) : s32(facc);
            F_PL:
            begin
                if (s16(facc) != 1) return raise(ST_PLANES, r);
            end
            F_BPP:
            begin
                code = depth_check(facc & 32'hFFFF);
                if (s16(facc) < 0) code = int'(ST_DEPTH);
                if (code >= 0) return raise(code[2:0], r);
                if (core_hdr) return header_done(r);
            end
            default:
            begin
                if (facc != 0 && facc != 3) return raise(ST_COMPRESSION, r);
                return header_done(r);
            end
        endcase
        return 1'b0;
    endfunction

    function automatic bit pixel_byte(input int unsigned b, output out_item_t r);
        int unsigned val, idx;
        bit          last;
        r = '0;
        last = 1'b0;
        if (d24)
        begin
            if (pbc == 0) begin ppart = b >> 3; pbc = 1; return 1'b0; end
            if (pbc == 1) begin ppart = ppart | ((b >> 2) << 5); pbc = 2; return 1'b0; end
            val = ppart | ((b >> 3) << 11);
        end
        else
        begin
            if (pbc == 0) begin ppart = b; pbc = 1; return 1'b0; end
            val = ppart | (b << 8);
        end
        pbc = 0;
        ppart = 0;
        r.kind = KIND_PIXEL;
        r.pixel_value = val[15:0];
        idx = rbase + col;
        r.pixel_index = idx[19:0];
        image_fields(r);
        col = col + 1;
        if (col >= wreg)
        begin
            col = 0;
            row = row + 1;
            if (row >= hreg)
            begin
                last = 1'b1;
                ph = P_DONE;
            end
            else
            begin
                set_row_base();
                padrem = rpad;
                if (padrem != 0) ph = P_PAD;
            end
        end
        r.last_pixel = last;
        return 1'b1;
    endfunction

    function automatic bit decode_item(input in_item_t it, output out_item_t r);
        int unsigned b;
        bit          has;
        r = '0;
        b = it.byte_value;
        if (it.action)
        begin
            has = 1'b0;
            case (ph)
                P_MAGIC0, P_MAGIC1: has = raise(ST_NOT_BMP, r);
                P_HEADER, P_SKIP:   has = raise(ST_TRUNC_HEADER, r);
                P_PIXELS, P_PAD:    has = raise(ST_PIXELS_SHORT, r);
                default:            has = 1'b0;
            endcase
            clear_state();
            return has;
        end
        case (ph)
            P_MAGIC0:
            begin
                if (it.byte_value != MAGIC_B) return raise(ST_NOT_BMP, r);
                ph = P_MAGIC1;
                boff = 1;
                return 1'b0;
            end
            P_MAGIC1:
            begin
                if (it.byte_value != MAGIC_M) return raise(ST_NOT_BMP, r);
                ph = P_HEADER;
                boff = 2;
                return 1'b0;
            end
            P_HEADER: return header_byte(b, r);
            P_SKIP:
            begin
                boff = boff + 1;
                if (s32(pstart) <= longint'(boff)) ph = P_PIXELS;
                return 1'b0;
            end
            P_PIXELS: return pixel_byte(b, r);
            P_PAD:
            begin
                if (padrem > 0) padrem = padrem - 1;
                if (padrem == 0) ph = P_PIXELS;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic out_item_t mk(input logic [1:0] kind, input logic [15:0] val,
                                     input logic [19:0] idx, input logic last,
                                     input logic [2:0] code, input logic [10:0] w,
                                     input logic [10:0] h, input logic b24, input logic td);
        out_item_t r;
        r = '{kind, val, idx, last, code, w, h, b24, td};
        return r;
    endfunction

    function automatic void add_row(input logic act, input logic [7:0] b, input bit typed,
                                    input bit want, input out_item_t res);
        table_row_t t;
        t.it = '{act, b};
        t.typed = typed;
        t.want = want;
        t.res = res;
        directed_rows.push_back(t);
    endfunction

    function automatic void put_le(ref byte unsigned f[$], input longint v, input int nb);
        for (int i = 0; i < nb; i++) f.push_back(byte'(v >> (8 * i)));
    endfunction

    function automatic void add_file();
        int          sel, w, h, bpp, planes, comp, dib, hdr_end, poff, n, cut;
        longint      bpr, fs, hh;
        bit          core, neg;
        byte unsigned f[$];
        sel = $urandom_range(0, 99);
        core = ($urandom_range(0, 3) == 0);
        w = $urandom_range(2, 9);
        h = $urandom_range(1, 4);
        bpp = $urandom_range(0, 1) ? 24 : 16;
        planes = 1;
        comp = $urandom_range(0, 1) ? 3 : 0;
        neg = ($urandom_range(0, 2) == 0);
        dib = core ? 12 : ($urandom_range(0, 1) ? 40 : 124);
        if (sel < 2)
        begin
            w = MAX_W;
            h = 1;
        end
        else if (sel == 2)
        begin
            w = 2;
            h = MAX_H;
            bpp = 16;
        end
        else if (sel < 9)
        begin
            case ($urandom_range(0, 5))
                0: w = 0;
                1: w = 1;
                2: w = MAX_W + 1;
                3: w = -3;
                4: h = 0;
                default: h = MAX_H + 1;
            endcase
        end
        else if (sel < 12)
            planes = $urandom_range(0, 1) ? 0 : $urandom_range(2, 65535);
        else if (sel < 15)
        begin
            case ($urandom_range(0, 4))
                0: bpp = 0;
                1: bpp = 8;
                2: bpp = 32;
                3: bpp = 'h8018;
                default: bpp = 'hFFFF;
            endcase
        end
        else if (sel < 18)
            comp = $urandom_range(0, 1) ? $urandom_range(1, 2) : $urandom_range(4, 'h7FFFFFFF);
        hdr_end = core ? 26 : 34;
        poff = hdr_end + $urandom_range(0, 4);
        if (sel >= 21 && sel < 25) poff = $urandom_range(0, hdr_end);
        if (sel == 25) poff = -16;
        bpr = (w > 0) ? 4 * ((longint'(bpp) * w + 31) / 32) : 4;
        fs = longint'(poff) + bpr * h;
        if (sel >= 18 && sel < 21)
            fs = fs + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 9);
        hh = neg ? -h : h;
        f.push_back(MAGIC_B);
        f.push_back(MAGIC_M);
        put_le(f, fs, 4);
        put_le(f, $urandom, 4);
        put_le(f, poff, 4);
        put_le(f, dib, 4);
        if (core)
        begin
            put_le(f, w, 2);
            put_le(f, hh, 2);
            put_le(f, planes, 2);
            put_le(f, bpp, 2);
        end
        else
        begin
            put_le(f, w, 4);
            put_le(f, hh, 4);
            put_le(f, planes, 2);
            put_le(f, bpp, 2);
            put_le(f, comp, 4);
        end
        for (int i = hdr_end; i < poff; i++) f.push_back(byte'($urandom_range(0, 255)));
        n = (sel < 21) ? $urandom_range(0, 6) : int'(bpr * h);
        for (int i = 0; i < n; i++) f.push_back(byte'($urandom_range(0, 255)));
        if (sel >= 26 && sel < 32)
            for (int i = $urandom_range(1, 5); i > 0; i--) f.push_back(byte'($urandom));
        cut = f.size();
        if (sel >= 32 && sel < 42) cut = $urandom_range(0, f.size() - 1);
        if (sel >= 42 && sel < 45)
        begin
            f.delete();
            for (int i = $urandom_range(1, 6); i > 0; i--) f.push_back(byte'($urandom));
            cut = f.size();
        end
        for (int i = 0; i < cut; i++) stim_items.push_back('{1'b0, f[i]});
        if (sel != 45) stim_items.push_back('{1'b1, 8'($urandom)});
    endfunction

    task automatic send(input in_item_t it, input bit typed, input bit want,
                        input out_item_t res);
        out_item_t got;
        bit        has;
        while (!quiet && $urandom_range(0, 99) < 26)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        has = decode_item(it, got);
        if (typed)
        begin
            if (want) pending_results.push_back(res);
        end
        else if (has)
            pending_results.push_back(got);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t e;
        if (pending_results.size() == 0)
        begin
            $error("result with nothing pending: kind %0h", got.kind);
            fail_count++;
            return;
        end
        e = pending_results.pop_front();
        if (got != e) fail_count++;
        if (got.kind != e.kind)
            $error("kind exp %0h got %0h", e.kind, got.kind);
        if (got.pixel_value != e.pixel_value)
            $error("pixel_value exp %0h got %0h", e.pixel_value, got.pixel_value);
        if (got.pixel_index != e.pixel_index)
            $error("pixel_index exp %0h got %0h", e.pixel_index, got.pixel_index);
        if (got.last_pixel != e.last_pixel)
            $error("last_pixel exp %0h got %0h", e.last_pixel, got.last_pixel);
        if (got.status_code != e.status_code)
            $error("status_code exp %0h got %0h", e.status_code, got.status_code);
        if (got.image_width != e.image_width)
            $error("image_width exp %0h got %0h", e.image_width, got.image_width);
        if (got.image_height != e.image_height)
            $error("image_height exp %0h got %0h", e.image_height, got.image_height);
        if (got.is_24bpp != e.is_24bpp)
            $error("is_24bpp exp %0h got %0h", e.is_24bpp, got.is_24bpp);
        if (got.top_down != e.top_down)
            $error("top_down exp %0h got %0h", e.top_down, got.top_down);
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int rx_cycles;
        int hold;
        rx_cycles = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
                rx_cycles++;
                if (rx_cycles == 1500) hold = 300;
                if (hold > 0)
                begin
                    hold--;
                    out_ch.ready <= 1'b0;
                end
                else
                    out_ch.ready <= quiet || ($urandom_range(0, 99) >= 26);
            end
        end
    end

    initial
    begin
        out_item_t none;
        none = '0;
        clear_state();

        add_row(1'b1, 8'h00, 1'b1, 1'b1, mk(KIND_ERROR, 16'd0, 20'd0, 1'b0, ST_NOT_BMP,
                                         11'd0, 11'd0, 1'b0, 1'b0));
        add_row(1'b0, 8'h00, 1'b1, 1'b1, mk(KIND_ERROR, 16'd0, 20'd0, 1'b0, ST_NOT_BMP,
                                         11'd0, 11'd0, 1'b0, 1'b0));
        add_row(1'b0, 8'hFF, 1'b1, 1'b0, none);
        add_row(1'b1, 8'hFF, 1'b1, 1'b0, none);
        add_row(1'b0, MAGIC_B, 1'b1, 1'b0, none);
        add_row(1'b0, MAGIC_M, 1'b1, 1'b0, none);
        add_row(1'b1, 8'h00, 1'b1, 1'b1, mk(KIND_ERROR, 16'd0, 20'd0, 1'b0, ST_TRUNC_HEADER,
                                         11'd0, 11'd0, 1'b0, 1'b0));
        // 2x1 core-header file at 16 bpp
        add_row(1'b0, MAGIC_B, 1'b0, 1'b0, none);
        add_row(1'b0, MAGIC_M, 1'b0, 1'b0, none);
        begin
            byte unsigned hdr[$];
            put_le(hdr, 30, 4);
            put_le(hdr, 0, 4);
            put_le(hdr, 26, 4);
            put_le(hdr, 12, 4);
            put_le(hdr, 2, 2);
            put_le(hdr, 1, 2);
            put_le(hdr, 1, 2);
            put_le(hdr, 16, 1);
            foreach (hdr[i]) add_row(1'b0, hdr[i], 1'b0, 1'b0, none);
        end
        add_row(1'b0, 8'h00, 1'b1, 1'b1, mk(KIND_HEADER, 16'd0, 20'd0, 1'b0, 3'd0,
                                         11'd2, 11'd1, 1'b0, 1'b0));
        add_row(1'b0, 8'h00, 1'b1, 1'b0, none);
        add_row(1'b0, 8'h00, 1'b1, 1'b1, mk(KIND_PIXEL, 16'h0000, 20'd0, 1'b0, 3'd0,
                                         11'd2, 11'd1, 1'b0, 1'b0));
        add_row(1'b0, 8'hFF, 1'b1, 1'b0, none);
        add_row(1'b0, 8'hFF, 1'b1, 1'b1, mk(KIND_PIXEL, 16'hFFFF, 20'd1, 1'b1, 3'd0,
                                         11'd2, 11'd1, 1'b0, 1'b0));
        add_row(1'b1, 8'h00, 1'b1, 1'b0, none);

        while (stim_items.size() < ITEM_COUNT)
        begin
            add_file();
            if (pause_at < 0 && stim_items.size() >= ITEM_COUNT / 2) pause_at = stim_items.size();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want,
                 directed_rows[i].res);

        foreach (stim_items[i])
        begin
            quiet = (i >= 200 && i < 500);
            if (i == pause_at)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0) @(posedge clk);
            end
            send(stim_items[i], 1'b0, 1'b0, none);
        end
        quiet = 1'b0;

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
